// ----- rtl/pss_pkg.sv -----
`timescale 1ns / 1ps

package pss_pkg;

  // Widths of the request and result fields.
  localparam int LIMIT_W = 17;
  localparam int SUM_W   = 32;

  // Default sieve size (largest limit the bitmap can hold).
  localparam int DEF_MAX_LIMIT = 65536;

  // The only even prime, added up front when the limit exceeds it.
  localparam int EVEN_PRIME = 2;

endpackage

// ----- rtl/pss_map.sv -----
`timescale 1ns / 1ps

// Composite bitmap: one write port, one registered read port.
module pss_map #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/pss_sqr.sv -----
`timescale 1ns / 1ps

// Registered squarer, shared by every odd prime found in the scan.
module pss_sqr #(
  parameter int W = 17
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  output logic [2*W-1:0] p
);

  logic [2*W-1:0] a_ext;

  assign a_ext = (2*W)'(a);

  always_ff @(posedge clk) begin
    p <= a_ext * a_ext;
  end

endmodule

// ----- rtl/pss_ctrl.sv -----
`timescale 1ns / 1ps

// Sieve sequencer: clear, scan, square check, mark, deliver.
module pss_ctrl #(
  parameter int MAX_LIMIT = 65536,
  localparam int MAP_DEPTH = MAX_LIMIT / 2,
  localparam int IW = $clog2(MAP_DEPTH),
  localparam int NW = IW + 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pss_pkg::LIMIT_W-1:0] in_limit,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pss_pkg::SUM_W-1:0] out_sum,
  output logic                      wr_en,
  output logic [IW-1:0]             wr_addr,
  output logic                      wr_data,
  output logic [IW-1:0]             rd_addr,
  input  logic                      rd_data,
  output logic [NW-1:0]             sq_in,
  input  logic [2*NW-1:0]           sq_out
);

  import pss_pkg::*;

  localparam int CW = IW + 1;
  localparam int JW = NW + 1;
  localparam int LW = $clog2(MAX_LIMIT + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_CHK    = 3'd3;
  localparam logic [2:0] ST_SQ     = 3'd4;
  localparam logic [2:0] ST_SQ_CHK = 3'd5;
  localparam logic [2:0] ST_MARK   = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]       state;
  logic [LW-1:0]    lim;
  logic [CW-1:0]    top;
  logic [CW-1:0]    idx;
  logic [NW-1:0]    n;
  logic [JW-1:0]    j;
  logic [SUM_W-1:0] sum;

  logic [LW-1:0]    lim_sat;
  logic             sat;
  logic [CW-1:0]    idx_inc;
  logic [NW-1:0]    n_cand;
  logic [JW-1:0]    j_next;
  logic             idx_in_range;

  assign sat     = 32'(in_limit) > 32'(MAX_LIMIT);
  assign lim_sat = sat ? LW'(MAX_LIMIT) : LW'(in_limit);
  assign idx_inc = idx + CW'(1);
  assign n_cand  = {idx, 1'b1};
  assign j_next  = j + JW'(n);
  assign idx_in_range = idx < top;

  assign in_ready = (state == ST_IDLE);
  assign sq_in    = n;
  assign rd_addr  = idx[IW-1:0];
  assign wr_en    = ((state == ST_CLEAR) && idx_in_range) || (state == ST_MARK);
  assign wr_addr  = (state == ST_MARK) ? j[IW-1:0] : idx[IW-1:0];
  assign wr_data  = (state == ST_MARK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in ST_DONE the hand-off below owns out_valid
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            lim   <= lim_sat;
            top   <= CW'(lim_sat >> 1);
            sum   <= (lim_sat > LW'(EVEN_PRIME)) ? SUM_W'(EVEN_PRIME) : '0;
            idx   <= '0;
            state <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          if (idx_in_range) begin
            idx <= idx_inc;
          end else begin
            idx   <= CW'(1);
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= idx_in_range ? ST_CHK : ST_DONE;
        end
        ST_CHK: begin
          if (rd_data) begin
            idx   <= idx_inc;
            state <= ST_RD;
          end else begin
            sum   <= sum + SUM_W'(n_cand);
            n     <= n_cand;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          state <= ST_SQ_CHK;
        end
        ST_SQ_CHK: begin
          // square is odd, so a shift gives (n*n-1)/2
          if (sq_out < (2*NW)'(lim)) begin
            j     <= JW'(sq_out >> 1);
            state <= ST_MARK;
          end else begin
            idx   <= idx_inc;
            state <= ST_RD;
          end
        end
        ST_MARK: begin
          j <= j_next;
          if (j_next >= JW'(top)) begin
            idx   <= idx_inc;
            state <= ST_RD;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_sum   <= sum;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/prime_sieve_sum_core.sv -----
`timescale 1ns / 1ps

// Channel  | dir | fields (low bit up)                    | accepted when
// ---------+-----+----------------------------------------+-------------------------
// s_*      | in  | tdata: limit[16:0], zero pad [23:17]   | s_tvalid && s_tready
// m_*      | out | tdata: prime_sum[31:0]                 | m_tvalid && m_tready
//
// One request at a time, with T = min(limit, MAX_LIMIT)/2: the sequencer clears
//   bitmap entries 0 to T-1, scans each odd index with a read and a check state,
//   runs a square state and a square check state per odd prime, writes a mark for
//   each multiple, then hands off the sum.
// The sequencer touches the bitmap once per cycle (one write or one read), and
// that sets the pace.
// rst is synchronous and clears the sequencer and the output valid; the bitmap
// needs no reset, since every request clears the part it uses.
// The result sits in an output register, so a stalled m_tready does not block the
// next request; only a second result waits until the first is taken.
module prime_sieve_sum_core #(
  parameter int MAX_LIMIT = pss_pkg::DEF_MAX_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [16:0] limit, [23:17] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] prime_sum
);

  import pss_pkg::*;

  // bit i of the map stands for the odd number 2i+1
  localparam int MAP_DEPTH = MAX_LIMIT / 2;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int NW        = MAP_AW + 2;

  logic              wr_en;
  logic [MAP_AW-1:0] wr_addr;
  logic              wr_data;
  logic [MAP_AW-1:0] rd_addr;
  logic              rd_data;
  logic [NW-1:0]     sq_in;
  logic [2*NW-1:0]   sq_out;

  pss_ctrl #(
    .MAX_LIMIT(MAX_LIMIT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_limit (s_tdata[LIMIT_W-1:0]),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_sum  (m_tdata),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .sq_in    (sq_in),
    .sq_out   (sq_out)
  );

  pss_map #(
    .DEPTH(MAP_DEPTH),
    .AW   (MAP_AW)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pss_sqr #(
    .W(NW)
  ) u_sqr (
    .clk(clk),
    .a  (sq_in),
    .p  (sq_out)
  );

endmodule
